/* hw/rtl/dmac_pkg.sv */
package dmac_pkg;

  localparam int NumChannels  = 4;
  localparam int ChanW        = 2;
  localparam int GxBurstUnits = 112;

  localparam logic [2:0] OpWrSrc  = 3'd0;
  localparam logic [2:0] OpWrDst  = 3'd1;
  localparam logic [2:0] OpWrCtl  = 3'd2;
  localparam logic [2:0] OpRdCtl  = 3'd3;
  localparam logic [2:0] OpTrig   = 3'd4;
  localparam logic [2:0] OpStep   = 3'd5;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindRead = 2'd1;
  localparam logic [1:0] KindCopy = 2'd2;

  localparam logic [0:0] CfgProcSel = 1'd0;
  localparam logic [0:0] CfgLegacy  = 1'd1;

  localparam logic [31:0] CountMask = 32'h001F_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  channel;
    logic [31:0] write_mask;
    logic [31:0] write_value;
    logic [2:0]  trigger_mode;
    logic [3:0]  trigger_channels;
    logic        gx_fifo_half_empty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic        copy_wide;
    logic [1:0]  active_channel;
    logic        transfer_done;
    logic        irq_raise;
  } out_item_t;

  // per-channel entry held in the channel memory
  typedef struct packed {
    logic [27:0] src_reg;
    logic [27:0] dst_reg;
    logic [31:0] ctl;
    logic [31:0] src_cnt;
    logic [31:0] dst_cnt;
    logic [20:0] units;
    logic [6:0]  burst;
  } chan_entry_t;

endpackage

/* hw/rtl/four_channel_dma_controller_core.sv */
// Four-channel DMA controller core. Each input transaction is a register access, a trigger or
// a step that moves one unit for the lowest pending channel, and every transaction yields
// exactly one result transaction (kind none for writes, triggers and idle steps). Channel state
// sits in a small synchronous memory (one entry per channel) that is read, modified and written
// back, so a register access or a step with a pending channel goes from accept through memory
// read to compute with write back and result. Triggers, unknown opcodes and steps with nothing
// pending produce their result at the accept edge. A finished result waits in the output
// register and the next transaction is accepted only once that register is free. Entries
// never written since reset read as zero through per-entry written flags. Pending flags, control
// enable bits and the start modes are mirrored in flip-flops so that triggers and channel
// selection need no memory read.
module four_channel_dma_controller_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dmac_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dmac_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  typedef enum logic [1:0] {StIdle, StRead, StWrite} state_e;

  state_e                 state_q;
  dmac_pkg::in_item_t     item_q;
  logic [1:0]             ch_q;
  logic                   proc_q, legacy_q;
  logic [3:0]             pend_q;
  dmac_pkg::chan_entry_t  mem_q [dmac_pkg::NumChannels];
  logic [3:0]             mem_vld_q;
  dmac_pkg::chan_entry_t  rd_q;
  dmac_pkg::chan_entry_t  wr_d;
  logic                   wr_en;
  logic [3:0]             pend_d;
  dmac_pkg::out_item_t    res_d, out_q;
  logic                   out_v_q;
  logic [1:0]             sel_ch;
  logic                   sel_found;
  logic [3:0]             trig_hit;
  logic [31:0]            ctl_mir_q [dmac_pkg::NumChannels];
  logic                   acc;
  logic                   acc_mem;

  assign in_ready_o  = (state_q == StIdle) && !out_v_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // accepted transaction and whether it needs the channel memory
  assign acc     = (state_q == StIdle) && in_valid_i && in_ready_o;
  assign acc_mem = (in_data_i.opcode <= dmac_pkg::OpRdCtl)
                   || (in_data_i.opcode == dmac_pkg::OpStep && sel_found);

  // lowest pending channel
  always_comb begin
    sel_ch = '0;
    sel_found = 1'b0;
    for (int i = dmac_pkg::NumChannels - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_ch = i[1:0];
        sel_found = 1'b1;
      end
    end
  end

  // trigger match against mirrored control words
  always_comb begin
    logic [3:0] m;
    m = proc_q ? {in_data_i.trigger_mode, 1'b0} : {1'b0, in_data_i.trigger_mode};
    for (int i = 0; i < dmac_pkg::NumChannels; i++) begin
      trig_hit[i] = in_data_i.trigger_channels[i] && ctl_mir_q[i][31]
                    && ({1'b0, ctl_mir_q[i][29:27]} == m);
    end
  end

  // modify stage
  always_comb begin
    logic [31:0] c, msk, nc, size;
    logic [1:0]  dsel, ssel;
    logic [2:0]  mode;
    logic        end_run, gx, lg;
    logic [6:0]  bn;
    logic [20:0] un;
    wr_d = rd_q;
    wr_en = 1'b0;
    pend_d = pend_q;
    res_d = '0;
    c = rd_q.ctl;
    dsel = c[22:21];
    ssel = c[24:23];
    mode = c[29:27];
    gx = item_q.gx_fifo_half_empty;
    size = c[26] ? 32'd4 : 32'd2;
    end_run = 1'b0;
    msk = item_q.write_mask;
    nc = '0;
    bn = rd_q.burst + 7'd1;
    un = rd_q.units - 21'd1;
    lg = legacy_q && (mode == 3'd6) && (ch_q == 2'd1 || ch_q == 2'd2);
    case (item_q.opcode)
      dmac_pkg::OpWrSrc: begin
        msk = msk & ((proc_q && ch_q == 2'd0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF);
        wr_d.src_reg = (rd_q.src_reg & ~msk[27:0]) | (item_q.write_value[27:0] & msk[27:0]);
        wr_en = 1'b1;
      end
      dmac_pkg::OpWrDst: begin
        msk = msk & ((proc_q && ch_q != 2'd3) ? 32'h07FF_FFFF : 32'h0FFF_FFFF);
        wr_d.dst_reg = (rd_q.dst_reg & ~msk[27:0]) | (item_q.write_value[27:0] & msk[27:0]);
        wr_en = 1'b1;
      end
      dmac_pkg::OpWrCtl: begin
        if (proc_q) msk = msk & ((ch_q == 2'd3) ? 32'hF7E0_FFFF : 32'hF7E0_3FFF);
        nc = (c & ~msk) | (item_q.write_value & msk);
        wr_d.ctl = nc;
        wr_en = 1'b1;
        if (nc[31] && nc[29:27] == 3'd7 && gx) pend_d[ch_q] = 1'b1;
        if (!c[31] && nc[31]) begin
          wr_d.dst_cnt = {4'd0, rd_q.dst_reg};
          wr_d.src_cnt = {4'd0, rd_q.src_reg};
          wr_d.units = nc[20:0];
          wr_d.burst = '0;
          if (nc[29:27] == 3'd0) pend_d[ch_q] = 1'b1;
        end
      end
      dmac_pkg::OpRdCtl: begin
        res_d.kind = dmac_pkg::KindRead;
        res_d.read_data = c & (legacy_q ? 32'hFFFF_0000 : 32'hFFFF_FFFF);
      end
      dmac_pkg::OpStep: begin
        if (pend_q[ch_q]) begin
          wr_en = 1'b1;
          res_d.active_channel = ch_q;
          if (lg) begin
            res_d.kind = dmac_pkg::KindCopy;
            res_d.copy_source = rd_q.src_cnt;
            res_d.copy_dest = rd_q.dst_cnt;
            res_d.copy_wide = 1'b1;
            if (ssel == 2'd0) wr_d.src_cnt = rd_q.src_cnt + 32'd4;
            else if (ssel == 2'd1) wr_d.src_cnt = rd_q.src_cnt - 32'd4;
            wr_d.burst = bn;
            if (bn >= 7'd4) end_run = 1'b1;
          end else if (rd_q.units == '0) begin
            end_run = 1'b1;
          end else begin
            res_d.kind = dmac_pkg::KindCopy;
            res_d.copy_source = rd_q.src_cnt;
            res_d.copy_dest = rd_q.dst_cnt;
            res_d.copy_wide = c[26];
            if (ssel == 2'd0) wr_d.src_cnt = rd_q.src_cnt + size;
            else if (ssel == 2'd1) wr_d.src_cnt = rd_q.src_cnt - size;
            if (dsel == 2'd0 || dsel == 2'd3) wr_d.dst_cnt = rd_q.dst_cnt + size;
            else if (dsel == 2'd1) wr_d.dst_cnt = rd_q.dst_cnt - size;
            wr_d.units = un;
            wr_d.burst = bn;
            if (un == '0) begin
              end_run = 1'b1;
            end else if (mode == 3'd7 && bn >= 7'(dmac_pkg::GxBurstUnits)) begin
              wr_d.burst = '0;
              pend_d[ch_q] = gx;
              res_d.transfer_done = 1'b1;
            end
          end
          if (end_run) begin
            wr_d.burst = '0;
            pend_d[ch_q] = 1'b0;
            res_d.transfer_done = 1'b1;
            if (c[25] && mode != 3'd0) begin
              wr_d.units = c[20:0];
              if (dsel == 2'd3) wr_d.dst_cnt = {4'd0, rd_q.dst_reg};
              if (mode == 3'd7 && gx) pend_d[ch_q] = 1'b1;
            end else begin
              wr_d.ctl = {1'b0, c[30:0]};
            end
            res_d.irq_raise = c[30];
          end
        end
      end
      default: ;
    endcase
  end

  // control, mirrors and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q <= '0;
      proc_q <= 1'b0;
      legacy_q <= 1'b0;
      out_v_q <= 1'b0;
      mem_vld_q <= '0;
      for (int i = 0; i < dmac_pkg::NumChannels; i++) ctl_mir_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dmac_pkg::CfgProcSel: proc_q <= cfg_data_i[0];
          dmac_pkg::CfgLegacy:  legacy_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (acc) begin
            if (in_data_i.opcode == dmac_pkg::OpTrig) pend_q <= pend_q | trig_hit;
            // memory transactions go through read and write back, the rest answer at once
            if (acc_mem) state_q <= StRead;
            else out_v_q <= 1'b1;
          end
        end
        StRead: state_q <= StWrite;
        StWrite: begin
          pend_q <= pend_d;
          if (wr_en) begin
            ctl_mir_q[ch_q] <= wr_d.ctl;
            mem_vld_q[ch_q] <= 1'b1;
          end
          out_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers and channel memory
  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= in_data_i;
      ch_q <= (in_data_i.opcode == dmac_pkg::OpStep) ? sel_ch : in_data_i.channel;
      if (!acc_mem) out_q <= '0;
    end
    if (state_q == StRead) rd_q <= mem_vld_q[ch_q] ? mem_q[ch_q] : '0;
    if (state_q == StWrite) begin
      if (wr_en) mem_q[ch_q] <= wr_d;
      out_q <= res_d;
    end
  end

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWrite |-> !out_v_q)
    else $error("result register busy at write back");
  a_kind_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind == dmac_pkg::KindCopy) |-> out_q.read_data == '0)
    else $error("copy result carries read data");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o)
    else $error("accepting while busy");

endmodule

/* dv/tb_four_channel_dma_controller_core.sv */
`timescale 1ns / 1ps

module tb_four_channel_dma_controller_core;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  dmac_pkg::in_item_t   in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  dmac_pkg::out_item_t  out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [0:0]           cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  four_channel_dma_controller_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the channel state
  logic [31:0] src_reg_q [dmac_pkg::NumChannels];
  logic [31:0] dst_reg_q [dmac_pkg::NumChannels];
  logic [31:0] ctl_q     [dmac_pkg::NumChannels];
  logic [31:0] src_cnt_q [dmac_pkg::NumChannels];
  logic [31:0] dst_cnt_q [dmac_pkg::NumChannels];
  logic [20:0] units_q   [dmac_pkg::NumChannels];
  logic [6:0]  burst_q   [dmac_pkg::NumChannels];
  bit          pending_q [dmac_pkg::NumChannels];
  bit          proc_sel_q;
  bit          legacy_q;

  dmac_pkg::out_item_t expected_results[$];
  int          mismatches;
  int          items_sent;
  bit          calm;

  function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] sel,
                                            logic [31:0] size);
    if (sel == 2'd0) return a + size;
    if (sel == 2'd1) return a - size;
    return a;
  endfunction

  // work out the result of one transaction and advance the shadow state
  task automatic dma_predict(input dmac_pkg::in_item_t it, output dmac_pkg::out_item_t r);
    logic [31:0] m, c, prev_ctl, size;
    logic [3:0]  tm;
    logic [1:0]  dsel, ssel;
    logic [2:0]  mode;
    int          ch, i;
    bit          found, end_run;
    r = '0;
    ch = it.channel;
    m = it.write_mask;
    case (it.opcode)
      dmac_pkg::OpWrSrc: begin
        m &= (!proc_sel_q || ch != 0) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
        src_reg_q[ch] = (src_reg_q[ch] & ~m) | (it.write_value & m);
      end
      dmac_pkg::OpWrDst: begin
        m &= (!proc_sel_q || ch == 3) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
        dst_reg_q[ch] = (dst_reg_q[ch] & ~m) | (it.write_value & m);
      end
      dmac_pkg::OpWrCtl: begin
        if (proc_sel_q) m &= (ch == 3) ? 32'hF7E0_FFFF : 32'hF7E0_3FFF;
        prev_ctl = ctl_q[ch];
        c = (prev_ctl & ~m) | (it.write_value & m);
        ctl_q[ch] = c;
        if (c[31] && c[29:27] == 3'd7 && it.gx_fifo_half_empty) pending_q[ch] = 1'b1;
        if (!prev_ctl[31] && c[31]) begin
          dst_cnt_q[ch] = dst_reg_q[ch];
          src_cnt_q[ch] = src_reg_q[ch];
          units_q[ch] = c[20:0];
          burst_q[ch] = '0;
          if (c[29:27] == 3'd0) pending_q[ch] = 1'b1;
        end
      end
      dmac_pkg::OpRdCtl: begin
        r.kind = dmac_pkg::KindRead;
        r.read_data = ctl_q[ch] & (legacy_q ? 32'hFFFF_0000 : 32'hFFFF_FFFF);
      end
      dmac_pkg::OpTrig: begin
        tm = proc_sel_q ? {it.trigger_mode, 1'b0} : {1'b0, it.trigger_mode};
        for (i = 0; i < dmac_pkg::NumChannels; i++)
          if (it.trigger_channels[i] && ctl_q[i][31] && {1'b0, ctl_q[i][29:27]} == tm)
            pending_q[i] = 1'b1;
      end
      dmac_pkg::OpStep: begin
        found = 1'b0;
        for (i = 0; i < dmac_pkg::NumChannels && !found; i++)
          if (pending_q[i]) begin
            found = 1'b1;
            ch = i;
          end
        if (found) begin
          c = ctl_q[ch];
          dsel = c[22:21];
          ssel = c[24:23];
          mode = c[29:27];
          end_run = 1'b0;
          r.active_channel = ch[1:0];
          if (legacy_q && mode == 3'd6 && (ch == 1 || ch == 2)) begin
            // legacy sound: four wide units to a fixed destination
            r.kind = dmac_pkg::KindCopy;
            r.copy_source = src_cnt_q[ch];
            r.copy_dest = dst_cnt_q[ch];
            r.copy_wide = 1'b1;
            src_cnt_q[ch] = next_addr(src_cnt_q[ch], ssel, 32'd4);
            burst_q[ch] = burst_q[ch] + 7'd1;
            if (burst_q[ch] >= 7'd4) end_run = 1'b1;
          end else if (units_q[ch] == '0) begin
            end_run = 1'b1;
          end else begin
            size = c[26] ? 32'd4 : 32'd2;
            r.kind = dmac_pkg::KindCopy;
            r.copy_source = src_cnt_q[ch];
            r.copy_dest = dst_cnt_q[ch];
            r.copy_wide = c[26];
            src_cnt_q[ch] = next_addr(src_cnt_q[ch], ssel, size);
            if (dsel == 2'd3) dst_cnt_q[ch] = dst_cnt_q[ch] + size;
            else dst_cnt_q[ch] = next_addr(dst_cnt_q[ch], dsel, size);
            units_q[ch] = units_q[ch] - 21'd1;
            burst_q[ch] = burst_q[ch] + 7'd1;
            if (units_q[ch] == '0) begin
              end_run = 1'b1;
            end else if (mode == 3'd7 && burst_q[ch] >= dmac_pkg::GxBurstUnits) begin
              // geometry burst boundary
              burst_q[ch] = '0;
              pending_q[ch] = it.gx_fifo_half_empty;
              r.transfer_done = 1'b1;
            end
          end
          if (end_run) begin
            burst_q[ch] = '0;
            pending_q[ch] = 1'b0;
            r.transfer_done = 1'b1;
            if (c[25] && mode != 3'd0) begin
              units_q[ch] = c[20:0];
              if (dsel == 2'd3) dst_cnt_q[ch] = dst_reg_q[ch];
              if (mode == 3'd7 && it.gx_fifo_half_empty) pending_q[ch] = 1'b1;
            end else begin
              ctl_q[ch] = c & 32'h7FFF_FFFF;
            end
            if (c[30]) r.irq_raise = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // send one transaction, with random gaps ahead of it
  task automatic send_item(input dmac_pkg::in_item_t it);
    dmac_pkg::out_item_t r;
    while (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    dma_predict(it, r);
    expected_results.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == dmac_pkg::CfgProcSel) proc_sel_q = data[0];
    else legacy_q = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic dmac_pkg::in_item_t mk(logic [2:0] op, logic [1:0] ch, logic [31:0] msk,
                                            logic [31:0] val, logic [2:0] tmode,
                                            logic [3:0] tch, logic gx);
    dmac_pkg::in_item_t it;
    it.opcode = op;
    it.channel = ch;
    it.write_mask = msk;
    it.write_value = val;
    it.trigger_mode = tmode;
    it.trigger_channels = tch;
    it.gx_fifo_half_empty = gx;
    return it;
  endfunction

  function automatic dmac_pkg::in_item_t noise_item();
    return mk(3'($urandom_range(7)), 2'($urandom_range(3)), $urandom, $urandom,
              3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)));
  endfunction

  // program one channel, start it and step it through its run
  task automatic channel_run();
    logic [1:0]  ch;
    logic [2:0]  mode;
    logic [20:0] cnt;
    logic [31:0] ctl;
    int          pick, steps;
    bit          gx;
    ch = legacy_q && $urandom_range(1) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
    pick = $urandom_range(9);
    mode = pick < 3 ? 3'd0 : pick == 3 ? 3'd6 : pick < 6 ? 3'd7 : 3'($urandom_range(7));
    cnt = 21'($urandom_range(6));
    if (mode == 3'd7 && $urandom_range(5) == 0) cnt = 21'($urandom_range(100, 130));
    gx = $urandom_range(9) < 7;
    ctl = {1'b1, 1'($urandom), mode, 1'($urandom), 1'($urandom), 2'($urandom),
           2'($urandom), cnt};
    if ($urandom_range(4) != 0)
      send_item(mk(dmac_pkg::OpWrCtl, ch, 32'hFFFF_FFFF, 32'h0, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpWrSrc, ch, 32'hFFFF_FFFF, $urandom, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpWrDst, ch, 32'hFFFF_FFFF, $urandom, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpWrCtl, ch, 32'hFFFF_FFFF, ctl, 3'd0, 4'd0, gx));
    if ($urandom_range(3) == 0) send_item(noise_item());
    send_item(mk(dmac_pkg::OpTrig, 2'd0, 32'h0, 32'h0, proc_sel_q ? mode >> 1 : mode,
                 4'($urandom) | (4'd1 << ch), 1'b0));
    steps = (cnt > 4 ? int'(cnt) : 4) + $urandom_range(1, 3);
    repeat (steps) begin
      if ($urandom_range(15) == 0) send_item(noise_item());
      send_item(mk(dmac_pkg::OpStep, 2'd0, $urandom, $urandom, 3'd0, 4'd0,
                   $urandom_range(9) < 8));
    end
    if ($urandom_range(1))
      send_item(mk(dmac_pkg::OpRdCtl, ch, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) send_item(noise_item());
      else channel_run();
    end
  endtask

  task automatic test_directed();
    int i;
    for (i = 0; i < dmac_pkg::NumChannels; i++)
      send_item(mk(dmac_pkg::OpRdCtl, 2'(i), 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpWrSrc, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 3'd7, 4'd15, 1'b1));
    send_item(mk(dmac_pkg::OpWrDst, 2'd0, 32'hFFFF_FFFF, 32'h0000_0100, 3'd0, 4'd0, 1'b0));
    // immediate start, two wide units, source down, irq
    send_item(mk(dmac_pkg::OpWrCtl, 2'd0, 32'hFFFF_FFFF, 32'hC480_0002, 3'd0, 4'd0, 1'b0));
    repeat (3) send_item(mk(dmac_pkg::OpStep, 2'd0, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    // zero count run ends at once
    send_item(mk(dmac_pkg::OpWrCtl, 2'd3, 32'hFFFF_FFFF, 32'hC000_0000, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpStep, 2'd0, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    // triggered start with repeat and dest reload, then a trigger while pending
    send_item(mk(dmac_pkg::OpWrCtl, 2'd2, 32'hFFFF_FFFF, 32'hAA60_0001, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpTrig, 2'd0, 32'h0, 32'h0, 3'd5, 4'b0100, 1'b0));
    send_item(mk(dmac_pkg::OpTrig, 2'd0, 32'h0, 32'h0, 3'd5, 4'b0100, 1'b0));
    send_item(mk(dmac_pkg::OpStep, 2'd0, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpRdCtl, 2'd2, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    // masked write leaves the rest, unknown opcodes do nothing
    send_item(mk(dmac_pkg::OpWrCtl, 2'd2, 32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 4'd0, 1'b1));
    send_item(mk(3'd6, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 4'd15, 1'b1));
    send_item(mk(3'd7, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 4'd15, 1'b1));
    send_item(mk(dmac_pkg::OpWrCtl, 2'd2, 32'h8000_0000, 32'h0, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpStep, 2'd0, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
    send_item(mk(dmac_pkg::OpRdCtl, 2'd0, 32'h0, 32'h0, 3'd0, 4'd0, 1'b0));
  endtask

  task automatic test_main_random();
    calm = 1'b1;
    random_phase(120);
    calm = 1'b0;
    random_phase(120);
    drain();
    random_phase(110);
  endtask

  task automatic test_secondary();
    write_cfg(dmac_pkg::CfgProcSel, 32'h1);
    random_phase(200);
  endtask

  task automatic test_legacy();
    write_cfg(dmac_pkg::CfgProcSel, 32'h0);
    write_cfg(dmac_pkg::CfgLegacy, 32'hFFFF_FFFF);
    random_phase(200);
    write_cfg(dmac_pkg::CfgProcSel, 32'hFFFF_FFFF);
    random_phase(150);
    write_cfg(dmac_pkg::CfgLegacy, 32'h0);
    random_phase(40);
  endtask

  // output ready, idling at random outside calm stretches
  always @(negedge clk_i)
    out_ready_i <= calm || ($urandom_range(99) >= 10);

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    dmac_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_data_o.kind), 32'hx);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.kind != want.kind)
          report_mismatch("kind", 32'(out_data_o.kind), 32'(want.kind));
        if (out_data_o.read_data != want.read_data)
          report_mismatch("read_data", out_data_o.read_data, want.read_data);
        if (out_data_o.copy_source != want.copy_source)
          report_mismatch("copy_source", out_data_o.copy_source, want.copy_source);
        if (out_data_o.copy_dest != want.copy_dest)
          report_mismatch("copy_dest", out_data_o.copy_dest, want.copy_dest);
        if (out_data_o.copy_wide != want.copy_wide)
          report_mismatch("copy_wide", 32'(out_data_o.copy_wide), 32'(want.copy_wide));
        if (out_data_o.active_channel != want.active_channel)
          report_mismatch("active_channel", 32'(out_data_o.active_channel),
                          32'(want.active_channel));
        if (out_data_o.transfer_done != want.transfer_done)
          report_mismatch("transfer_done", 32'(out_data_o.transfer_done),
                          32'(want.transfer_done));
        if (out_data_o.irq_raise != want.irq_raise)
          report_mismatch("irq_raise", 32'(out_data_o.irq_raise), 32'(want.irq_raise));
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < dmac_pkg::NumChannels; i++) begin
      src_reg_q[i] = '0; dst_reg_q[i] = '0; ctl_q[i] = '0;
      src_cnt_q[i] = '0; dst_cnt_q[i] = '0; units_q[i] = '0;
      burst_q[i] = '0; pending_q[i] = 1'b0;
    end
    proc_sel_q = 1'b0;
    legacy_q = 1'b0;
    mismatches = 0;
    items_sent = 0;
    calm = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_main_random();
    test_secondary();
    test_legacy();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
